>>> rtl/lightweight_spn_block_cipher_64_assert.svh
// Assertion macros for the lightweight SPN block cipher core.
// Included by the top level; no other dependencies.
`ifndef LIGHTWEIGHT_SPN_BLOCK_CIPHER_64_ASSERT_SVH
`define LIGHTWEIGHT_SPN_BLOCK_CIPHER_64_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset only.
`define LSBC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsbc assertion failed");
// Next-cycle implication, checked out of reset only.
`define LSBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsbc assertion failed");
`else
`define LSBC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LSBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lsbc_pkg.sv
// Package for the lightweight SPN block cipher core: tables, codes and round functions.
// No dependencies; imported by lightweight_spn_block_cipher_64.
`timescale 1ns / 1ps
`default_nettype none

package lsbc_pkg;

  // Round count after reset, and the number of round stages (largest 6-bit count).
  localparam int unsigned MAX_ROUNDS = 28;
  localparam int unsigned NUM_STAGES = 63;
  // Accept edge to result strobe: input register plus the round stages.
  localparam int unsigned LATENCY    = NUM_STAGES + 1;

  localparam logic [1:0] CFG_KEY_LOW     = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH    = 2'd1;
  localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [3:0] nibble_table_t [16];
  typedef logic [5:0] perm_table_t [64];
  typedef logic [5:0] rc_table_t [64];

  localparam nibble_table_t SBOX = '{
    4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
    4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
  };

  localparam nibble_table_t SBOX_INV = '{
    4'd13, 4'd0, 4'd8, 4'd6, 4'd2, 4'd12, 4'd4, 4'd11,
    4'd14, 4'd7, 4'd1, 4'd10, 4'd3, 4'd9, 4'd15, 4'd5
  };

  localparam perm_table_t PERM = '{
    6'd0,  6'd17, 6'd34, 6'd51, 6'd48, 6'd1,  6'd18, 6'd35,
    6'd32, 6'd49, 6'd2,  6'd19, 6'd16, 6'd33, 6'd50, 6'd3,
    6'd4,  6'd21, 6'd38, 6'd55, 6'd52, 6'd5,  6'd22, 6'd39,
    6'd36, 6'd53, 6'd6,  6'd23, 6'd20, 6'd37, 6'd54, 6'd7,
    6'd8,  6'd25, 6'd42, 6'd59, 6'd56, 6'd9,  6'd26, 6'd43,
    6'd40, 6'd57, 6'd10, 6'd27, 6'd24, 6'd41, 6'd58, 6'd11,
    6'd12, 6'd29, 6'd46, 6'd63, 6'd60, 6'd13, 6'd30, 6'd47,
    6'd44, 6'd61, 6'd14, 6'd31, 6'd28, 6'd45, 6'd62, 6'd15
  };

  // Round constants from the 6-bit LFSR seeded with 1, built at elaboration.
  function automatic rc_table_t rc_table_gen();
    rc_table_t   t;
    logic [5:0]  c;
    c = 6'h01;
    for (int i = 0; i < 64; i++) begin
      t[i] = c;
      c    = {c[4:0], ~(c[5] ^ c[4])};
    end
    return t;
  endfunction

  localparam rc_table_t RC_TABLE = rc_table_gen();

  function automatic logic [63:0] sub_nibbles(input logic [63:0] s, input logic inv);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = inv ? SBOX_INV[s[4*i +: 4]] : SBOX[s[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_fwd(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[PERM[i]] = s[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_inv(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = s[PERM[i]];
    end
    return r;
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] w, input logic [3:0] amt);
    logic [31:0] d;
    d = {w, w} >> amt;
    return d[15:0];
  endfunction

  // Round key of round r straight from the master key: the key words walk down
  // two places a round, so round r sees words 2(r mod 4) and 2(r mod 4)+1, each
  // rotated once per earlier pass through the bottom (floor(r/4) passes).
  // Returns {U, V}.
  function automatic logic [31:0] round_key(input logic [63:0] key_lo,
                                            input logic [63:0] key_hi,
                                            input logic [5:0]  r);
    logic [127:0] k;
    logic [3:0]   q;
    logic [15:0]  v;
    logic [15:0]  u;
    k = {key_hi, key_lo};
    q = r[5:2];
    v = rotr16(k[{r[1:0], 5'd0} +: 16], 4'(q * 4'd12));
    u = rotr16(k[{r[1:0], 5'd16} +: 16], {q[2:0], 1'b0});
    return {u, v};
  endfunction

  function automatic logic [63:0] add_key(input logic [63:0] s,
                                          input logic [31:0] rk,
                                          input logic [5:0]  c);
    logic [63:0] r;
    r = s;
    for (int i = 0; i < 16; i++) begin
      r[4*i]     = r[4*i] ^ rk[i];
      r[4*i + 1] = r[4*i + 1] ^ rk[16 + i];
    end
    for (int i = 0; i < 6; i++) begin
      r[4*i + 3] = r[4*i + 3] ^ c[i];
    end
    r[63] = ~r[63];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lightweight_spn_block_cipher_64.sv
// Lightweight SPN block cipher core (64-bit block, 128-bit key), fully unrolled pipeline.
// Depends on lsbc_pkg and lightweight_spn_block_cipher_64_assert.svh.
//
//   channel   handshake            payload
//   input     start & !busy        command, block_in
//   result    done (strobe)        block_out
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One block is taken every cycle; busy stays low, and with no result back-pressure
// nothing stalls. The strobe's timing does not depend on the round count: each block
// passes an input register and then 63 round stages, one per possible round, the later
// stages passing the block through unchanged.
// Decryption stage j runs round count-1-j, with its key and constant looked up.
// Reset clears the valid bits and key halves and sets the round count to MAX_ROUNDS; blocks in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "lightweight_spn_block_cipher_64_assert.svh"

module lightweight_spn_block_cipher_64
  import lsbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [63:0] block_in,
  output logic             done,
  output logic      [63:0] block_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] key_low_half;
  logic [63:0] key_high_half;
  logic [5:0]  round_count;

  logic        stage_valid [NUM_STAGES+1];
  logic        stage_cmd   [NUM_STAGES+1];
  logic [5:0]  stage_n     [NUM_STAGES+1];
  logic [63:0] stage_block [NUM_STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_half  <= '0;
      key_high_half <= '0;
      round_count   <= 6'(MAX_ROUNDS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_LOW:     key_low_half  <= cfg_data;
        CFG_KEY_HIGH:    key_high_half <= cfg_data;
        CFG_ROUND_COUNT: round_count   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_cmd[0]   <= command;
      stage_n[0]     <= round_count;
      stage_block[0] <= block_in;
    end
  end

  for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_round
    localparam logic [5:0] J = 6'(k - 1);

    logic        active;
    logic [5:0]  r_sel;
    logic [31:0] rk;
    logic [5:0]  rc;
    logic [63:0] enc_block;
    logic [63:0] dec_block;
    logic [63:0] block_next;

    assign active    = stage_n[k-1] > J;
    assign r_sel     = (stage_cmd[k-1] == CMD_DECRYPT) ? 6'(stage_n[k-1] - J - 6'd1) : J;
    assign rk        = round_key(key_low_half, key_high_half, r_sel);
    assign rc        = RC_TABLE[r_sel];
    assign enc_block = add_key(perm_fwd(sub_nibbles(stage_block[k-1], 1'b0)), rk, rc);
    assign dec_block = sub_nibbles(perm_inv(add_key(stage_block[k-1], rk, rc)), 1'b1);

    always_comb begin
      if (!active) begin
        block_next = stage_block[k-1];
      end else if (stage_cmd[k-1] == CMD_DECRYPT) begin
        block_next = dec_block;
      end else begin
        block_next = enc_block;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else begin
        stage_valid[k] <= stage_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_valid[k-1]) begin
        stage_cmd[k]   <= stage_cmd[k-1];
        stage_n[k]     <= stage_n[k-1];
        stage_block[k] <= block_next;
      end
    end
  end

  assign done      = stage_valid[NUM_STAGES];
  assign block_out = stage_block[NUM_STAGES];

  // Fixed latency from accept to strobe
  `LSBC_ASSERT_IMPLIES(a_latency, clk, rst, start && !busy, ##LATENCY done)
  // Zero rounds leaves the block untouched all the way down
  `LSBC_ASSERT_IMPLIES(a_zero_round_pass, clk, rst,
    stage_valid[0] && (stage_n[0] == 6'd0),
    ##NUM_STAGES (done && (block_out == $past(stage_block[0], NUM_STAGES))))
  // Round count write lands in the register
  `LSBC_ASSERT_NEXT(a_cfg_rounds, clk, rst,
    cfg_valid && cfg_ready && (cfg_index == CFG_ROUND_COUNT),
    round_count == $past(cfg_data[5:0]))

endmodule

`default_nettype wire
